// ----- rtl/rcr_pkg.sv -----
// Shared types, constants and saturation helpers for the rigid contact response block.
// Used by every module under rtl; depends on nothing else.
`default_nettype none
package rcr_pkg;

   localparam int FieldWidth = 32;
   localparam int DataWidth  = 32;
   localparam int FracBits   = 16;
   localparam int DistWidth  = 2 * FieldWidth;
   localparam int RemWidth   = DistWidth + 1;
   localparam int CrossWidth = DataWidth + FieldWidth;
   localparam int MatWidth   = FieldWidth + DataWidth;
   localparam int UWidth     = MatWidth + 2 - FracBits;
   localparam int UHiWidth   = UWidth - FieldWidth;
   localparam int QWidth     = UWidth + DataWidth + 2;
   localparam int QuoBits    = 34;
   localparam int LimShift   = QuoBits - FracBits;
   localparam int TotalWidth = QuoBits + 3;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 64;

   typedef enum logic [1:0] {
      StatusOk   = 2'd0,
      StatusSat  = 2'd1,
      StatusZero = 2'd2
   } status_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CsrCenterXy    = 3'd0,
      CsrCenterZ     = 3'd1,
      CsrInverseMass = 3'd2,
      CsrInertiaXxYy = 3'd3,
      CsrInertiaZzXy = 3'd4,
      CsrInertiaXzYz = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic zero;
      logic sat;
   } ctl_type;

   typedef struct packed {
      logic signed [FieldWidth-1:0] trans_x;
      logic signed [FieldWidth-1:0] trans_y;
      logic signed [FieldWidth-1:0] trans_z;
      logic signed [FieldWidth-1:0] rot_x;
      logic signed [FieldWidth-1:0] rot_y;
      logic signed [FieldWidth-1:0] rot_z;
   } accel_type;

   // saturate to a signed output field; flag in the top bit
   function automatic logic [FieldWidth:0] sat_field(input logic signed [127:0] v);
      logic signed [127:0] hi;
      logic signed [127:0] lo;
      hi = 128'((64'sd1 <<< (FieldWidth - 1)) - 64'sd1);
      lo = -hi - 128'sd1;
      if (v > hi) begin
         return {1'b1, hi[FieldWidth-1:0]};
      end else if (v < lo) begin
         return {1'b1, lo[FieldWidth-1:0]};
      end
      return {1'b0, v[FieldWidth-1:0]};
   endfunction

   // saturate to the internal data width; flag in the top bit
   function automatic logic [DataWidth:0] sat_data(input logic signed [127:0] v);
      logic signed [127:0] hi;
      logic signed [127:0] lo;
      hi = 128'((64'sd1 <<< (DataWidth - 1)) - 64'sd1);
      lo = -hi - 128'sd1;
      if (v > hi) begin
         return {1'b1, hi[DataWidth-1:0]};
      end else if (v < lo) begin
         return {1'b1, lo[DataWidth-1:0]};
      end
      return {1'b0, v[DataWidth-1:0]};
   endfunction

endpackage
`default_nettype wire

// ----- rtl/rcr_front.sv -----
// Front stages: lever arm, torque, translational acceleration and squared force length.
// Depends on rcr_pkg.
`default_nettype none
module rcr_front (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      en,
   input  wire logic                                      in_valid,
   input  wire logic signed [rcr_pkg::FieldWidth-1:0]     point_x,
   input  wire logic signed [rcr_pkg::FieldWidth-1:0]     point_y,
   input  wire logic signed [rcr_pkg::FieldWidth-1:0]     point_z,
   input  wire logic signed [rcr_pkg::FieldWidth-1:0]     force_x,
   input  wire logic signed [rcr_pkg::FieldWidth-1:0]     force_y,
   input  wire logic signed [rcr_pkg::FieldWidth-1:0]     force_z,
   input  wire logic signed [rcr_pkg::FieldWidth-1:0]     center_x,
   input  wire logic signed [rcr_pkg::FieldWidth-1:0]     center_y,
   input  wire logic signed [rcr_pkg::FieldWidth-1:0]     center_z,
   input  wire logic        [rcr_pkg::FieldWidth-1:0]     inv_mass,
   output rcr_pkg::ctl_type                               ctl_out,
   output logic signed [rcr_pkg::DataWidth-1:0]           torque_out [3],
   output logic signed [rcr_pkg::FieldWidth-1:0]          trans_out [3],
   output logic        [rcr_pkg::DistWidth-1:0]           dist_out
);
   localparam int FW = rcr_pkg::FieldWidth;
   localparam int DW = rcr_pkg::DataWidth;
   localparam int F  = rcr_pkg::FracBits;
   localparam int PW = rcr_pkg::CrossWidth;
   localparam int TW = 2 * FW;

   logic signed [FW-1:0] p_in [3];
   logic signed [FW-1:0] f_in [3];
   logic signed [FW-1:0] c_in [3];

   assign p_in[0] = point_x;
   assign p_in[1] = point_y;
   assign p_in[2] = point_z;
   assign f_in[0] = force_x;
   assign f_in[1] = force_y;
   assign f_in[2] = force_z;
   assign c_in[0] = center_x;
   assign c_in[1] = center_y;
   assign c_in[2] = center_z;

   // stage 1: lever arm and force squares
   rcr_pkg::ctl_type       s1_ctl_ff, s1_ctl_in;
   logic signed [DW-1:0]   s1_r_ff [3];
   logic signed [DW-1:0]   s1_r_in [3];
   logic signed [FW-1:0]   s1_f_ff [3];
   logic [TW-1:0]          s1_sq_ff [3];
   logic [TW-1:0]          s1_sq_in [3];

   always_comb begin
      logic [DW:0] rs;
      s1_ctl_in.valid = in_valid;
      s1_ctl_in.zero  = (force_x == '0) && (force_y == '0) && (force_z == '0);
      s1_ctl_in.sat   = 1'b0;
      for (int i = 0; i < 3; i++) begin
         rs = rcr_pkg::sat_data(128'(p_in[i]) - 128'(c_in[i]));
         s1_r_in[i] = rs[DW-1:0];
         s1_ctl_in.sat = s1_ctl_in.sat | rs[DW];
         s1_sq_in[i] = TW'(TW'(f_in[i]) * TW'(f_in[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else if (en) begin
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_r_ff  <= s1_r_in;
         s1_f_ff  <= f_in;
         s1_sq_ff <= s1_sq_in;
      end
   end

   // stage 2: cross products, force times inverse mass, squared length
   rcr_pkg::ctl_type       s2_ctl_ff;
   logic signed [PW-1:0]   s2_pa_ff [3];
   logic signed [PW-1:0]   s2_pb_ff [3];
   logic signed [PW-1:0]   s2_pa_in [3];
   logic signed [PW-1:0]   s2_pb_in [3];
   logic signed [TW-1:0]   s2_tr_ff [3];
   logic signed [TW-1:0]   s2_tr_in [3];
   logic [TW-1:0]          s2_dist_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_pa_in[i] = PW'(s1_r_ff[(i + 1) % 3]) * PW'(s1_f_ff[(i + 2) % 3]);
         s2_pb_in[i] = PW'(s1_r_ff[(i + 2) % 3]) * PW'(s1_f_ff[(i + 1) % 3]);
         s2_tr_in[i] = TW'(s1_f_ff[i]) * $signed(TW'(inv_mass));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else if (en) begin
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_pa_ff   <= s2_pa_in;
         s2_pb_ff   <= s2_pb_in;
         s2_tr_ff   <= s2_tr_in;
         s2_dist_ff <= s1_sq_ff[0] + s1_sq_ff[1] + s1_sq_ff[2];
      end
   end

   // stage 3: torque and translational acceleration with saturation
   rcr_pkg::ctl_type       s3_ctl_ff, s3_ctl_in;
   logic signed [DW-1:0]   s3_t_ff [3];
   logic signed [DW-1:0]   s3_t_in [3];
   logic signed [FW-1:0]   s3_tr_ff [3];
   logic signed [FW-1:0]   s3_tr_in [3];
   logic [TW-1:0]          s3_dist_ff;

   always_comb begin
      logic [DW:0] ts;
      logic [FW:0] as;
      s3_ctl_in = s2_ctl_ff;
      for (int i = 0; i < 3; i++) begin
         ts = rcr_pkg::sat_data((128'(s2_pa_ff[i]) - 128'(s2_pb_ff[i])) >>> F);
         s3_t_in[i] = ts[DW-1:0];
         as = rcr_pkg::sat_field(128'(s2_tr_ff[i]) >>> F);
         s3_tr_in[i] = as[FW-1:0];
         s3_ctl_in.sat = s3_ctl_in.sat | ts[DW] | as[FW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else if (en) begin
         s3_ctl_ff <= s3_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_t_ff    <= s3_t_in;
         s3_tr_ff   <= s3_tr_in;
         s3_dist_ff <= s2_dist_ff;
      end
   end

   assign ctl_out    = s3_ctl_ff;
   assign torque_out = s3_t_ff;
   assign trans_out  = s3_tr_ff;
   assign dist_out   = s3_dist_ff;

endmodule
`default_nettype wire

// ----- rtl/rcr_quad.sv -----
// Middle stages: inverse inertia times torque, the quadratic form and divider setup.
// Depends on rcr_pkg.
`default_nettype none
module rcr_quad (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      en,
   input  wire rcr_pkg::ctl_type                          ctl_in,
   input  wire logic signed [rcr_pkg::DataWidth-1:0]      torque_in [3],
   input  wire logic signed [rcr_pkg::FieldWidth-1:0]     trans_in [3],
   input  wire logic        [rcr_pkg::DistWidth-1:0]      dist_in,
   input  wire logic        [3*rcr_pkg::CsrDataWidth-1:0] inertia,
   output rcr_pkg::ctl_type                               ctl_out,
   output rcr_pkg::accel_type                             accel_out,
   output logic        [rcr_pkg::DistWidth-1:0]           dist_out,
   output logic                                           neg_out,
   output logic                                           huge_out,
   output logic        [rcr_pkg::DistWidth-1:0]           rem_out,
   output logic        [rcr_pkg::QuoBits-1:0]             num_out
);
   localparam int FW  = rcr_pkg::FieldWidth;
   localparam int DW  = rcr_pkg::DataWidth;
   localparam int F   = rcr_pkg::FracBits;
   localparam int MW  = rcr_pkg::MatWidth;
   localparam int UW  = rcr_pkg::UWidth;
   localparam int UHW = rcr_pkg::UHiWidth;
   localparam int QW  = rcr_pkg::QWidth;
   localparam int LW  = DW + FW + 1;
   localparam int HW  = DW + UHW;
   localparam int DSW = rcr_pkg::DistWidth;
   localparam int LS  = rcr_pkg::LimShift;

   logic signed [FW-1:0] mat [3][3];

   assign mat[0][0] = inertia[31:0];
   assign mat[1][1] = inertia[63:32];
   assign mat[2][2] = inertia[95:64];
   assign mat[0][1] = inertia[127:96];
   assign mat[1][0] = inertia[127:96];
   assign mat[0][2] = inertia[159:128];
   assign mat[2][0] = inertia[159:128];
   assign mat[1][2] = inertia[191:160];
   assign mat[2][1] = inertia[191:160];

   // stage 4: matrix products
   rcr_pkg::ctl_type       s4_ctl_ff;
   logic signed [MW-1:0]   s4_mp_ff [3][3];
   logic signed [MW-1:0]   s4_mp_in [3][3];
   logic signed [DW-1:0]   s4_t_ff [3];
   logic signed [FW-1:0]   s4_tr_ff [3];
   logic [DSW-1:0]         s4_dist_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            s4_mp_in[i][j] = MW'(mat[i][j]) * MW'(torque_in[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctl_ff <= '0;
      end else if (en) begin
         s4_ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_mp_ff   <= s4_mp_in;
         s4_t_ff    <= torque_in;
         s4_tr_ff   <= trans_in;
         s4_dist_ff <= dist_in;
      end
   end

   // stage 5: row sums, shift and rotational acceleration
   rcr_pkg::ctl_type       s5_ctl_ff, s5_ctl_in;
   logic signed [UW-1:0]   s5_u_ff [3];
   logic signed [UW-1:0]   s5_u_in [3];
   logic signed [DW-1:0]   s5_t_ff [3];
   rcr_pkg::accel_type     s5_acc_ff, s5_acc_in;
   logic [DSW-1:0]         s5_dist_ff;

   always_comb begin
      logic signed [MW+1:0] usum;
      logic [FW:0] rs [3];
      s5_ctl_in = s4_ctl_ff;
      for (int i = 0; i < 3; i++) begin
         usum = (MW + 2)'(s4_mp_ff[i][0]) + (MW + 2)'(s4_mp_ff[i][1])
              + (MW + 2)'(s4_mp_ff[i][2]);
         s5_u_in[i] = UW'(usum >>> F);
         rs[i] = rcr_pkg::sat_field(128'(s5_u_in[i]));
         s5_ctl_in.sat = s5_ctl_in.sat | rs[i][FW];
      end
      s5_acc_in.trans_x = s4_tr_ff[0];
      s5_acc_in.trans_y = s4_tr_ff[1];
      s5_acc_in.trans_z = s4_tr_ff[2];
      s5_acc_in.rot_x   = rs[0][FW-1:0];
      s5_acc_in.rot_y   = rs[1][FW-1:0];
      s5_acc_in.rot_z   = rs[2][FW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_ctl_ff <= '0;
      end else if (en) begin
         s5_ctl_ff <= s5_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_u_ff    <= s5_u_in;
         s5_t_ff    <= s4_t_ff;
         s5_acc_ff  <= s5_acc_in;
         s5_dist_ff <= s4_dist_ff;
      end
   end

   // stage 6: torque times u, split into low and high partial products
   rcr_pkg::ctl_type       s6_ctl_ff;
   logic signed [LW-1:0]   s6_lo_ff [3];
   logic signed [LW-1:0]   s6_lo_in [3];
   logic signed [HW-1:0]   s6_hi_ff [3];
   logic signed [HW-1:0]   s6_hi_in [3];
   rcr_pkg::accel_type     s6_acc_ff;
   logic [DSW-1:0]         s6_dist_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s6_lo_in[i] = LW'(s5_t_ff[i]) * $signed(LW'(s5_u_ff[i][FW-1:0]));
         s6_hi_in[i] = HW'(s5_t_ff[i]) * HW'($signed(s5_u_ff[i][UW-1:FW]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_ctl_ff <= '0;
      end else if (en) begin
         s6_ctl_ff <= s5_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_lo_ff   <= s6_lo_in;
         s6_hi_ff   <= s6_hi_in;
         s6_acc_ff  <= s5_acc_ff;
         s6_dist_ff <= s5_dist_ff;
      end
   end

   // stage 7: recombine partial products
   rcr_pkg::ctl_type       s7_ctl_ff;
   logic signed [QW-1:0]   s7_qi_ff [3];
   logic signed [QW-1:0]   s7_qi_in [3];
   rcr_pkg::accel_type     s7_acc_ff;
   logic [DSW-1:0]         s7_dist_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s7_qi_in[i] = (QW'(s6_hi_ff[i]) <<< FW) + QW'(s6_lo_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_ctl_ff <= '0;
      end else if (en) begin
         s7_ctl_ff <= s6_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_qi_ff   <= s7_qi_in;
         s7_acc_ff  <= s6_acc_ff;
         s7_dist_ff <= s6_dist_ff;
      end
   end

   // stage 8: quadratic form
   rcr_pkg::ctl_type       s8_ctl_ff;
   logic signed [QW-1:0]   s8_q_ff;
   rcr_pkg::accel_type     s8_acc_ff;
   logic [DSW-1:0]         s8_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_ctl_ff <= '0;
      end else if (en) begin
         s8_ctl_ff <= s7_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s8_q_ff    <= s7_qi_ff[0] + s7_qi_ff[1] + s7_qi_ff[2];
         s8_acc_ff  <= s7_acc_ff;
         s8_dist_ff <= s7_dist_ff;
      end
   end

   // stage 9: magnitude, range check against the divider limit, first remainder
   rcr_pkg::ctl_type            s9_ctl_ff;
   rcr_pkg::accel_type          s9_acc_ff;
   logic [DSW-1:0]              s9_dist_ff;
   logic                        s9_neg_ff;
   logic                        s9_huge_ff;
   logic [DSW-1:0]              s9_rem_ff;
   logic [rcr_pkg::QuoBits-1:0] s9_num_ff;
   logic [QW-1:0]               mag;
   logic [QW-1:0]               lim;

   assign mag = s8_q_ff[QW-1] ? QW'(-s8_q_ff) : QW'(s8_q_ff);
   assign lim = QW'(s8_dist_ff) << LS;

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_ctl_ff <= '0;
      end else if (en) begin
         s9_ctl_ff <= s8_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s9_acc_ff  <= s8_acc_ff;
         s9_dist_ff <= s8_dist_ff;
         s9_neg_ff  <= s8_q_ff[QW-1];
         s9_huge_ff <= mag >= lim;
         s9_rem_ff  <= DSW'(mag >> LS);
         s9_num_ff  <= {mag[LS-1:0], F'(0)};
      end
   end

   assign ctl_out   = s9_ctl_ff;
   assign accel_out = s9_acc_ff;
   assign dist_out  = s9_dist_ff;
   assign neg_out   = s9_neg_ff;
   assign huge_out  = s9_huge_ff;
   assign rem_out   = s9_rem_ff;
   assign num_out   = s9_num_ff;

endmodule
`default_nettype wire

// ----- rtl/rcr_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with the result sideband.
// Depends on rcr_pkg.
`default_nettype none
module rcr_div (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               en,
   input  wire rcr_pkg::ctl_type                   ctl_in,
   input  wire rcr_pkg::accel_type                 accel_in,
   input  wire logic [rcr_pkg::DistWidth-1:0]      dist_in,
   input  wire logic                               neg_in,
   input  wire logic                               huge_in,
   input  wire logic [rcr_pkg::DistWidth-1:0]      rem_in,
   input  wire logic [rcr_pkg::QuoBits-1:0]        num_in,
   output rcr_pkg::ctl_type                        ctl_out,
   output rcr_pkg::accel_type                      accel_out,
   output logic                                    neg_out,
   output logic                                    huge_out,
   output logic [rcr_pkg::QuoBits-1:0]             quo_out
);
   localparam int N   = rcr_pkg::QuoBits;
   localparam int DSW = rcr_pkg::DistWidth;
   localparam int RW  = rcr_pkg::RemWidth;

   rcr_pkg::ctl_type   ctl_at [N];
   rcr_pkg::accel_type acc_at [N];
   logic [DSW-1:0]     dist_at [N];
   logic               neg_at [N];
   logic               huge_at [N];
   logic [DSW-1:0]     rem_at [N];
   logic [N-1:0]       num_at [N];
   logic [N-1:0]       quo_at [N];

   rcr_pkg::ctl_type   ctl_ff [N];
   rcr_pkg::accel_type acc_ff [N];
   logic [DSW-1:0]     dist_ff [N];
   logic               neg_ff [N];
   logic               huge_ff [N];
   logic [DSW-1:0]     rem_ff [N];
   logic [N-1:0]       num_ff [N];
   logic [N-1:0]       quo_ff [N];

   assign ctl_at[0]  = ctl_in;
   assign acc_at[0]  = accel_in;
   assign dist_at[0] = dist_in;
   assign neg_at[0]  = neg_in;
   assign huge_at[0] = huge_in;
   assign rem_at[0]  = rem_in;
   assign num_at[0]  = num_in;
   assign quo_at[0]  = '0;

   for (genvar s = 0; s < N; s++) begin : g_stage
      logic [RW-1:0] shifted;
      logic          ge;

      if (s > 0) begin : g_link
         assign ctl_at[s]  = ctl_ff[s-1];
         assign acc_at[s]  = acc_ff[s-1];
         assign dist_at[s] = dist_ff[s-1];
         assign neg_at[s]  = neg_ff[s-1];
         assign huge_at[s] = huge_ff[s-1];
         assign rem_at[s]  = rem_ff[s-1];
         assign num_at[s]  = num_ff[s-1];
         assign quo_at[s]  = quo_ff[s-1];
      end

      assign shifted = {rem_at[s], num_at[s][N-1-s]};
      assign ge      = shifted >= RW'(dist_at[s]);

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s] <= '0;
         end else if (en) begin
            ctl_ff[s] <= ctl_at[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[s]  <= acc_at[s];
            dist_ff[s] <= dist_at[s];
            neg_ff[s]  <= neg_at[s];
            huge_ff[s] <= huge_at[s];
            num_ff[s]  <= num_at[s];
            rem_ff[s]  <= ge ? DSW'(shifted - RW'(dist_at[s])) : DSW'(shifted);
            quo_ff[s]  <= {quo_at[s][N-2:0], ge};
         end
      end
   end

   assign ctl_out   = ctl_ff[N-1];
   assign accel_out = acc_ff[N-1];
   assign neg_out   = neg_ff[N-1];
   assign huge_out  = huge_ff[N-1];
   assign quo_out   = quo_ff[N-1];

endmodule
`default_nettype wire

// ----- rtl/rigid_contact_response.sv -----
// Rigid contact response: top level with configuration registers and the output stage.
// Depends on rcr_pkg, rcr_front, rcr_quad and rcr_div.
//
// Usage:
//   Each transfer on the req_ channel carries a contact point and a force vector.
//   Exactly one transfer on the rsp_ channel follows it, in order: inverse
//   effective mass along the force, translational and rotational acceleration
//   and a status code (ok, saturated, zero force).
//   The pipeline has three front stages, six stages for the inertia product
//   and quadratic form, 34 divider stages (one quotient bit each) and the output
//   register. Throughput is one transfer per cycle while the receiver does not stall.
//   The csr_ port writes one register per cycle; write it only while no
//   transfer is in flight.
//   Reset clears the registers and empties the pipeline.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and req_stall rises; nothing is dropped or repeated.
`default_nettype none
module rigid_contact_response (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [rcr_pkg::FieldWidth-1:0]  req_point_x,
   input  wire logic signed [rcr_pkg::FieldWidth-1:0]  req_point_y,
   input  wire logic signed [rcr_pkg::FieldWidth-1:0]  req_point_z,
   input  wire logic signed [rcr_pkg::FieldWidth-1:0]  req_force_x,
   input  wire logic signed [rcr_pkg::FieldWidth-1:0]  req_force_y,
   input  wire logic signed [rcr_pkg::FieldWidth-1:0]  req_force_z,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic        [rcr_pkg::FieldWidth-1:0]       rsp_inv_eff_mass,
   output logic signed [rcr_pkg::FieldWidth-1:0]       rsp_trans_accel_x,
   output logic signed [rcr_pkg::FieldWidth-1:0]       rsp_trans_accel_y,
   output logic signed [rcr_pkg::FieldWidth-1:0]       rsp_trans_accel_z,
   output logic signed [rcr_pkg::FieldWidth-1:0]       rsp_rot_accel_x,
   output logic signed [rcr_pkg::FieldWidth-1:0]       rsp_rot_accel_y,
   output logic signed [rcr_pkg::FieldWidth-1:0]       rsp_rot_accel_z,
   output logic        [1:0]                           rsp_status,
   input  wire logic                                   csr_write_en,
   input  wire logic   [rcr_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic   [rcr_pkg::CsrDataWidth-1:0]     csr_data
);
   localparam int FW  = rcr_pkg::FieldWidth;
   localparam int DW  = rcr_pkg::DataWidth;
   localparam int DSW = rcr_pkg::DistWidth;
   localparam int CW  = rcr_pkg::CsrDataWidth;
   localparam int N   = rcr_pkg::QuoBits;
   localparam int TOW = rcr_pkg::TotalWidth;

   logic [CW-1:0] center_xy_ff;
   logic [FW-1:0] center_z_ff;
   logic [FW-1:0] inv_mass_ff;
   logic [CW-1:0] inertia_xx_yy_ff;
   logic [CW-1:0] inertia_zz_xy_ff;
   logic [CW-1:0] inertia_xz_yz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_xy_ff     <= '0;
         center_z_ff      <= '0;
         inv_mass_ff      <= '0;
         inertia_xx_yy_ff <= '0;
         inertia_zz_xy_ff <= '0;
         inertia_xz_yz_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            rcr_pkg::CsrCenterXy:    center_xy_ff     <= csr_data;
            rcr_pkg::CsrCenterZ:     center_z_ff      <= csr_data[FW-1:0];
            rcr_pkg::CsrInverseMass: inv_mass_ff      <= csr_data[FW-1:0];
            rcr_pkg::CsrInertiaXxYy: inertia_xx_yy_ff <= csr_data;
            rcr_pkg::CsrInertiaZzXy: inertia_zz_xy_ff <= csr_data;
            rcr_pkg::CsrInertiaXzYz: inertia_xz_yz_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic en;
   logic rsp_valid_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   rcr_pkg::ctl_type   fr_ctl;
   logic signed [DW-1:0] fr_torque [3];
   logic signed [FW-1:0] fr_trans [3];
   logic [DSW-1:0]       fr_dist;

   rcr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_valid),
      .point_x    (req_point_x),
      .point_y    (req_point_y),
      .point_z    (req_point_z),
      .force_x    (req_force_x),
      .force_y    (req_force_y),
      .force_z    (req_force_z),
      .center_x   ($signed(center_xy_ff[FW-1:0])),
      .center_y   ($signed(center_xy_ff[CW-1:FW])),
      .center_z   ($signed(center_z_ff)),
      .inv_mass   (inv_mass_ff),
      .ctl_out    (fr_ctl),
      .torque_out (fr_torque),
      .trans_out  (fr_trans),
      .dist_out   (fr_dist)
   );

   rcr_pkg::ctl_type   qd_ctl;
   rcr_pkg::accel_type qd_acc;
   logic [DSW-1:0]     qd_dist;
   logic               qd_neg;
   logic               qd_huge;
   logic [DSW-1:0]     qd_rem;
   logic [N-1:0]       qd_num;

   rcr_quad u_quad (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .ctl_in    (fr_ctl),
      .torque_in (fr_torque),
      .trans_in  (fr_trans),
      .dist_in   (fr_dist),
      .inertia   ({inertia_xz_yz_ff, inertia_zz_xy_ff, inertia_xx_yy_ff}),
      .ctl_out   (qd_ctl),
      .accel_out (qd_acc),
      .dist_out  (qd_dist),
      .neg_out   (qd_neg),
      .huge_out  (qd_huge),
      .rem_out   (qd_rem),
      .num_out   (qd_num)
   );

   rcr_pkg::ctl_type   dv_ctl;
   rcr_pkg::accel_type dv_acc;
   logic               dv_neg;
   logic               dv_huge;
   logic [N-1:0]       dv_quo;

   rcr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .ctl_in    (qd_ctl),
      .accel_in  (qd_acc),
      .dist_in   (qd_dist),
      .neg_in    (qd_neg),
      .huge_in   (qd_huge),
      .rem_in    (qd_rem),
      .num_in    (qd_num),
      .ctl_out   (dv_ctl),
      .accel_out (dv_acc),
      .neg_out   (dv_neg),
      .huge_out  (dv_huge),
      .quo_out   (dv_quo)
   );

   // output stage: add inverse mass, clamp, pick status
   logic [FW-1:0]          inv_eff_in, inv_eff_ff;
   rcr_pkg::accel_type     acc_in, acc_ff;
   rcr_pkg::status_type    status_in, status_ff;

   always_comb begin
      logic signed [TOW-1:0] total;
      logic                  sat;
      sat = dv_ctl.sat;
      if (dv_huge) begin
         total = dv_neg ? -TOW'(1) : TOW'(64'h1_0000_0000);
      end else if (dv_neg) begin
         total = $signed(TOW'(inv_mass_ff)) - $signed(TOW'(dv_quo));
      end else begin
         total = $signed(TOW'(inv_mass_ff)) + $signed(TOW'(dv_quo));
      end
      if (total < 0) begin
         inv_eff_in = '0;
         sat = 1'b1;
      end else if (total > $signed(TOW'({FW{1'b1}}))) begin
         inv_eff_in = '1;
         sat = 1'b1;
      end else begin
         inv_eff_in = total[FW-1:0];
      end
      acc_in    = dv_acc;
      status_in = sat ? rcr_pkg::StatusSat : rcr_pkg::StatusOk;
      if (dv_ctl.zero) begin
         inv_eff_in = inv_mass_ff;
         acc_in     = '0;
         status_in  = rcr_pkg::StatusZero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         inv_eff_ff <= inv_eff_in;
         acc_ff     <= acc_in;
         status_ff  <= status_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_inv_eff_mass  = inv_eff_ff;
   assign rsp_trans_accel_x = acc_ff.trans_x;
   assign rsp_trans_accel_y = acc_ff.trans_y;
   assign rsp_trans_accel_z = acc_ff.trans_z;
   assign rsp_rot_accel_x   = acc_ff.rot_x;
   assign rsp_rot_accel_y   = acc_ff.rot_y;
   assign rsp_rot_accel_z   = acc_ff.rot_z;
   assign rsp_status        = status_ff;

`ifndef NO_ASSERTIONS
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result valid right after reset");

   a_zero_force_accel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == rcr_pkg::StatusZero |->
         acc_ff == '0)
      else $error("zero force with nonzero acceleration");

   a_zero_force_mass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == rcr_pkg::StatusZero |-> inv_eff_ff == inv_mass_ff)
      else $error("zero force result differs from inverse mass");

   a_hold_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("input taken while output holds");
`endif

endmodule
`default_nettype wire
